// File: rtl/sit_pkg.sv
// Shared types and constants for the sorted interval timer queue.
`timescale 1ns / 1ps
package sit_pkg;

  localparam int MAX_RESULTS = 16;
  localparam int NW = $clog2(MAX_RESULTS);

  localparam logic [2:0] KIND_STARTED    = 3'd0;
  localparam logic [2:0] KIND_BOTH_ZERO  = 3'd1;
  localparam logic [2:0] KIND_NO_HANDLER = 3'd2;
  localparam logic [2:0] KIND_FULL       = 3'd3;
  localparam logic [2:0] KIND_FIRED      = 3'd4;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_START = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [31:0] initial_interval;
    logic [31:0] repeat_interval;
    logic [15:0] handler_tag;
  } in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] timer_id;
    logic [15:0] fired_tag;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [63:0] expiry;
    logic [31:0] period;
    logic [31:0] id;
    logic [15:0] tag;
  } entry_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_POP
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    entry_t   ins;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_FIRE,
    ST_REINS
  } state_t;

endpackage

// File: rtl/sorted_interval_timer_queue.sv
// Top level of the sorted interval timer queue.
// Start: on acceptance the result is registered; a valid start then inserts its
// entry in the START state. Tick: the tick count advances, the FIRE state pops due
// entries (waiting while the output stalls), then REINS re-inserts periodic entries.
// Items are taken one at a time; the queue chain moves one shift per cycle.
// Synchronous active-low reset empties the queue, clears the tick count, id = 1.
`timescale 1ns / 1ps
module sorted_interval_timer_queue #(
  parameter int DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  sit_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output sit_pkg::out_t out_data
);

  localparam int CW = $clog2(DEPTH + 1);

  sit_pkg::state_t state_r, state_nxt;
  logic [63:0]     tick_r, tick_nxt;
  logic [31:0]     id_r, id_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [sit_pkg::NW-1:0] n_r, n_nxt;
  sit_pkg::entry_t ins_r, ins_nxt;
  logic            out_valid_r, out_valid_nxt;
  sit_pkg::out_t   out_data_r, out_data_nxt;

  sit_pkg::cell_ctl_t ctl;
  sit_pkg::entry_t    e_w [DEPTH];
  logic [DEPTH-1:0]   lt_w;
  logic               push, pop;
  sit_pkg::entry_t    push_e, stk_top;
  logic               stk_empty;
  logic               slot_free, due0, due1, last_w, accept;
  logic [31:0]        iv;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      sit_cell u_cell (
        .clk    (clk),
        .ctl    (ctl),
        .occ    (CW'(g) < count_r),
        .left_lt((g == 0) ? 1'b1 : lt_w[(g == 0) ? 0 : g - 1]),
        .left_e ((g == 0) ? ctl.ins : e_w[(g == 0) ? 0 : g - 1]),
        .right_e((g == DEPTH - 1) ? e_w[g] : e_w[(g == DEPTH - 1) ? g : g + 1]),
        .lt     (lt_w[g]),
        .e      (e_w[g])
      );
    end
  endgenerate

  sit_stack #(.DEPTH(DEPTH)) u_stack (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push),
    .pop  (pop),
    .din  (push_e),
    .top  (stk_top),
    .empty(stk_empty)
  );

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == sit_pkg::ST_IDLE) && slot_free;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign due0      = (count_r != '0) && (e_w[0].expiry <= tick_r);
  assign due1      = (count_r > CW'(1)) && (e_w[1].expiry <= tick_r);
  assign last_w    = (n_r == sit_pkg::NW'(sit_pkg::MAX_RESULTS - 1)) || !due1;
  assign iv        = (in_data.initial_interval != '0) ? in_data.initial_interval
                                                     : in_data.repeat_interval;

  always_comb begin
    push_e        = e_w[0];
    push_e.expiry = e_w[0].expiry + {32'd0, e_w[0].period};
  end

  always_comb begin
    state_nxt     = state_r;
    tick_nxt      = tick_r;
    id_nxt        = id_r;
    count_nxt     = count_r;
    n_nxt         = n_r;
    ins_nxt       = ins_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    ctl.op        = sit_pkg::OP_HOLD;
    ctl.ins       = ins_r;
    push          = 1'b0;
    pop           = 1'b0;
    case (state_r)
      sit_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_data.cmd == sit_pkg::CMD_TICK) begin
            tick_nxt  = tick_r + 64'd1;
            n_nxt     = '0;
            state_nxt = sit_pkg::ST_FIRE;
          end else begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{kind: sit_pkg::KIND_STARTED, timer_id: '0,
                              fired_tag: '0, last: 1'b1};
            if (in_data.initial_interval == '0 && in_data.repeat_interval == '0)
              out_data_nxt.kind = sit_pkg::KIND_BOTH_ZERO;
            else if (in_data.handler_tag == '0)
              out_data_nxt.kind = sit_pkg::KIND_NO_HANDLER;
            else if (count_r >= CW'(DEPTH))
              out_data_nxt.kind = sit_pkg::KIND_FULL;
            else begin
              out_data_nxt.timer_id = id_r;
              id_nxt         = id_r + 32'd1;
              ins_nxt.expiry = tick_r + {32'd0, iv};
              ins_nxt.period = in_data.repeat_interval;
              ins_nxt.id     = id_r;
              ins_nxt.tag    = in_data.handler_tag;
              state_nxt      = sit_pkg::ST_START;
            end
          end
        end
      end
      sit_pkg::ST_START: begin
        ctl.op    = sit_pkg::OP_INSERT;
        count_nxt = count_r + CW'(1);
        state_nxt = sit_pkg::ST_IDLE;
      end
      sit_pkg::ST_FIRE: begin
        if (!due0) begin
          state_nxt = sit_pkg::ST_REINS;
        end else if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{kind: sit_pkg::KIND_FIRED, timer_id: e_w[0].id,
                            fired_tag: e_w[0].tag, last: last_w};
          ctl.op    = sit_pkg::OP_POP;
          count_nxt = count_r - CW'(1);
          push      = (e_w[0].period != '0);
          n_nxt     = n_r + sit_pkg::NW'(1);
          if (last_w) state_nxt = sit_pkg::ST_REINS;
        end
      end
      sit_pkg::ST_REINS: begin
        // newest pending first, which is reverse firing order
        if (!stk_empty) begin
          ctl.op    = sit_pkg::OP_INSERT;
          ctl.ins   = stk_top;
          pop       = 1'b1;
          count_nxt = count_r + CW'(1);
        end else begin
          state_nxt = sit_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sit_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sit_pkg::ST_IDLE;
      tick_r      <= '0;
      id_r        <= 32'd1;
      count_r     <= '0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tick_r      <= tick_nxt;
      id_r        <= id_nxt;
      count_r     <= count_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ins_r      <= ins_nxt;
    out_data_r <= out_data_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH)) else $error("queue count beyond depth");

  a_idle_stack_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sit_pkg::ST_IDLE |-> stk_empty) else $error("pending entries left in idle");

  a_fire_pops: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.op == sit_pkg::OP_POP |=> out_valid_r && out_data_r.kind == sit_pkg::KIND_FIRED)
    else $error("pop without fired transaction");

endmodule

// File: rtl/sit_cell.sv
// One slot of the sorted queue: holds an entry and shifts with its neighbours.
`timescale 1ns / 1ps
module sit_cell (
  input  logic               clk,
  input  sit_pkg::cell_ctl_t ctl,
  input  logic               occ,
  input  logic               left_lt,
  input  sit_pkg::entry_t    left_e,
  input  sit_pkg::entry_t    right_e,
  output logic               lt,
  output sit_pkg::entry_t    e
);

  sit_pkg::entry_t e_r;
  sit_pkg::entry_t e_nxt;

  assign lt = occ && (e_r.expiry < ctl.ins.expiry);
  assign e  = e_r;

  always_comb begin
    e_nxt = e_r;
    case (ctl.op)
      sit_pkg::OP_INSERT: begin
        // keep smaller entries, take the new one at the boundary, shift the rest right
        if (lt) e_nxt = e_r;
        else if (left_lt) e_nxt = ctl.ins;
        else e_nxt = left_e;
      end
      sit_pkg::OP_POP: e_nxt = right_e;
      default: e_nxt = e_r;
    endcase
  end

  always_ff @(posedge clk) begin
    e_r <= e_nxt;
  end

endmodule

// File: rtl/sit_stack.sv
// Shift-register stack for periodic entries awaiting re-insertion.
`timescale 1ns / 1ps
module sit_stack #(
  parameter int DEPTH = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  logic            pop,
  input  sit_pkg::entry_t din,
  output sit_pkg::entry_t top,
  output logic            empty
);

  localparam int SW = $clog2(DEPTH + 1);

  sit_pkg::entry_t s_r [DEPTH];
  logic [SW-1:0]   sp_r;
  logic [SW-1:0]   sp_nxt;

  assign top   = s_r[0];
  assign empty = (sp_r == '0);

  always_comb begin
    sp_nxt = sp_r;
    if (push) sp_nxt = sp_r + SW'(1);
    else if (pop) sp_nxt = sp_r - SW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= '0;
    end else begin
      sp_r <= sp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (push) s_r[i] <= (i == 0) ? din : s_r[(i == 0) ? 0 : i - 1];
      else if (pop) s_r[i] <= (i == DEPTH - 1) ? s_r[i] : s_r[(i == DEPTH - 1) ? i : i + 1];
    end
  end

endmodule
